>>> hdl/frame_rms_envelope_assert.svh
// assertion macros shared by the rms envelope modules
`ifndef FRAME_RMS_ENVELOPE_ASSERT_SVH
`define FRAME_RMS_ENVELOPE_ASSERT_SVH
`define FRE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/fre_pkg.sv
`default_nettype none
package fre_pkg;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int LEVEL_FRAC_BITS_DEF = 16;
   localparam int SR_W = 18;
   localparam int FR_W = 10;
   localparam int GAIN_W = 17;
   localparam int LEVEL_W = 17;
   localparam int SUM_W = 48;
   localparam int CNT_W = 18;
   localparam int CSR_W = 18;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTHING_GAIN = 2'd2;
   localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
   localparam logic [FR_W-1:0] FR_RESET = 10'd60;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd18580;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

   typedef struct packed {
      logic signed [15:0] sample;
      logic last_sample;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic final_frame;
   } rsp_type;

   // one closed window handed to the back end
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic last;
   } win_type;
endpackage
`default_nettype wire

>>> hdl/fre_front.sv
`default_nettype none
module fre_front #(
   parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic in_last,
   output logic in_ready,
   input  wire logic [fre_pkg::SR_W-1:0] sample_rate,
   input  wire logic [fre_pkg::FR_W-1:0] frame_rate,
   output logic win_valid,
   output fre_pkg::win_type win,
   input  wire logic win_ready,
   output logic clr_smooth
);
   localparam int SQ_W = 2 * SAMPLE_BITS;
   localparam int SW = fre_pkg::SUM_W;
   localparam int CW = fre_pkg::CNT_W;
   localparam int RW = fre_pkg::SR_W;
   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_MOD = 2'd1;

   // stage 1: magnitude, stage 2: square, accumulate and boundary
   logic s1_ff, s1_in;
   logic [SAMPLE_BITS-1:0] mag_ff, mag_in;
   logic last1_ff, last1_in;
   logic [SQ_W-1:0] sq;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] res_ff, res_in;
   logic [1:0] state_ff, state_in;
   logic win_valid_ff, win_valid_in;
   fre_pkg::win_type win_ff, win_in;
   logic clr_ff, clr_in;
   logic bad;
   logic [RW:0] z, zc, rn;
   logic close;
   logic [SW:0] sum_add;

   assign bad = sample_rate == '0 || frame_rate == '0 ||
                {{(RW-fre_pkg::FR_W){1'b0}}, frame_rate} > sample_rate;
   assign in_ready = !s1_ff && !win_valid_ff && state_ff == ST_RUN;
   assign win_valid = win_valid_ff;
   assign win = win_ff;
   assign clr_smooth = clr_ff;
   assign sq = SQ_W'(mag_ff) * SQ_W'(mag_ff);

   always_comb begin
      s1_in = 1'b0;
      mag_in = mag_ff;
      last1_in = last1_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      state_in = state_ff;
      win_valid_in = win_valid_ff && !win_ready;
      win_in = win_ff;
      clr_in = 1'b0;
      z = '0;
      zc = '0;
      rn = '0;
      close = 1'b0;
      sum_add = {1'b0, sum_ff} + (SW+1)'(sq);
      case (state_ff)
         ST_MOD: begin
            // reduce residual after a rate change, one subtract a cycle
            if (res_ff >= sample_rate) begin
               res_in = res_ff - sample_rate;
            end else begin
               state_in = ST_RUN;
               s1_in = 1'b1;
            end
         end
         default: begin
            if (in_valid && in_ready) begin
               if (bad) begin
                  if (in_last) begin
                     sum_in = '0;
                     cnt_in = '0;
                     res_in = '0;
                     clr_in = 1'b1;
                  end
               end else begin
                  mag_in = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample) : in_sample;
                  last1_in = in_last;
                  if (res_ff >= sample_rate) state_in = ST_MOD;
                  else s1_in = 1'b1;
               end
            end else if (s1_ff) begin
               sum_in = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
               if (cnt_ff != {CW{1'b1}}) cnt_in = cnt_ff + 1'b1;
               z = {1'b0, res_ff} + (RW+1)'(frame_rate) - 1'b1;
               if (z >= {1'b0, sample_rate}) z = z - {1'b0, sample_rate};
               zc = z + (RW+1)'(frame_rate);
               close = zc >= {1'b0, sample_rate};
               rn = {1'b0, res_ff} + (RW+1)'(frame_rate);
               if (rn >= {1'b0, sample_rate}) rn = rn - {1'b0, sample_rate};
               res_in = rn[RW-1:0];
               if (close || last1_ff) begin
                  win_valid_in = 1'b1;
                  win_in.sum = sum_in;
                  win_in.count = cnt_in;
                  win_in.last = last1_ff;
                  sum_in = '0;
                  cnt_in = '0;
                  if (last1_ff) res_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
         res_ff <= '0;
         state_ff <= ST_RUN;
         win_valid_ff <= 1'b0;
         clr_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         res_ff <= res_in;
         state_ff <= state_in;
         win_valid_ff <= win_valid_in;
         clr_ff <= clr_in;
      end
      mag_ff <= mag_in;
      last1_ff <= last1_in;
      win_ff <= win_in;
   end

   `include "frame_rms_envelope_assert.svh"
   `FRE_ASSERT(a_one_busy, clock, reset, !(s1_ff && win_valid_ff), "square stage with window pending")
   `FRE_ASSERT_NEXT(a_win_hold, clock, reset, win_valid_ff && !win_ready, win_valid_ff && $stable(win_ff), "window dropped")
   `FRE_ASSERT(a_res_range, clock, reset, !(state_ff == ST_RUN && s1_ff) || res_ff < sample_rate, "residual not reduced")
endmodule
`default_nettype wire

>>> hdl/fre_back.sv
`default_nettype none
module fre_back #(
   parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = fre_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic win_valid,
   input  wire fre_pkg::win_type win,
   output logic win_ready,
   input  wire logic clr_smooth,
   input  wire logic [fre_pkg::GAIN_W-1:0] smoothing_gain,
   output logic out_valid,
   output fre_pkg::rsp_type out_data,
   input  wire logic out_ready
);
   localparam int K = 2 * (LEVEL_FRAC_BITS - SAMPLE_BITS + 1);
   localparam int KP = (K > 0) ? K : 0;
   localparam int KN = (K < 0) ? -K : 0;
   localparam int SW = fre_pkg::SUM_W;
   localparam int CW = fre_pkg::CNT_W;
   localparam int DW = CW + KN;
   localparam int QW = SW + KP;
   localparam int LIM = 2 * LEVEL_FRAC_BITS;
   localparam int RTW = LEVEL_FRAC_BITS + 1;
   localparam int LW = fre_pkg::LEVEL_W;
   localparam int GW = fre_pkg::GAIN_W;
   localparam int SQI = (LIM + 1) / 2;
   localparam int NW = QW + 1;
   localparam int ITW = $clog2(QW + 1);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [QW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [ITW-1:0] it_ff, it_in;
   logic [LIM-1:0] sx_ff, sx_in;
   logic [LIM+1:0] sr_ff, sr_in;
   logic [RTW-1:0] rms_ff, rms_in;
   logic last_ff, last_in;
   logic [LW-1:0] sm_ff, sm_in;
   logic [LW+GW:0] p0_ff, p0_in, p1_ff, p1_in;
   logic out_valid_ff, out_valid_in;
   fre_pkg::rsp_type out_ff, out_in;
   logic [NW-1:0] rtry;
   logic [GW-1:0] g;
   logic [LW+GW:0] acc;
   logic [LIM+1:0] sbit, strial;
   logic [LIM-1:0] sxn;

   assign win_ready = state_ff == ST_IDLE && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data = out_ff;
   assign g = smoothing_gain > fre_pkg::GAIN_ONE ? fre_pkg::GAIN_ONE : smoothing_gain;

   always_comb begin
      state_in = state_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      it_in = it_ff;
      sx_in = sx_ff;
      sr_in = sr_ff;
      rms_in = rms_ff;
      last_in = last_ff;
      sm_in = clr_smooth ? '0 : sm_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in = out_ff;
      rtry = {rem_ff[NW-2:0], num_ff[QW-1]} - NW'(den_ff);
      sbit = '0;
      strial = '0;
      sxn = sx_ff;
      acc = p0_ff + p1_ff + (LW+GW+1)'(32768);
      case (state_ff)
         ST_IDLE: begin
            if (win_valid && win_ready) begin
               num_in = QW'(win.sum) << KP;
               den_in = DW'(win.count) << KN;
               rem_in = '0;
               quo_in = '0;
               it_in = '0;
               last_in = win.last;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (den_ff == '0) begin
               rms_in = '0;
               state_in = ST_MUL;
            end else begin
               num_in = num_ff << 1;
               if (!rtry[NW-1]) begin
                  rem_in = rtry;
                  quo_in = {quo_ff[QW-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[NW-2:0], num_ff[QW-1]};
                  quo_in = {quo_ff[QW-2:0], 1'b0};
               end
               it_in = it_ff + 1'b1;
               if (it_ff == ITW'(QW - 1)) begin
                  if (quo_in[QW-1:LIM] != '0) begin
                     rms_in = RTW'(1) << LEVEL_FRAC_BITS;
                     state_in = ST_MUL;
                  end else begin
                     sx_in = quo_in[LIM-1:0];
                     sr_in = '0;
                     it_in = '0;
                     state_in = ST_SQRT;
                  end
               end
            end
         end
         ST_SQRT: begin
            // digit-by-digit root, one result bit a cycle
            sbit = (LIM+2)'(1) << (2 * (SQI - 1 - int'(it_ff)));
            strial = sr_ff + sbit;
            if ((LIM+2)'(sx_ff) >= strial) begin
               sxn = sx_ff - LIM'(strial);
               sr_in = (sr_ff >> 1) + sbit;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sx_in = sxn;
            it_in = it_ff + 1'b1;
            if (it_ff == ITW'(SQI - 1)) begin
               rms_in = RTW'(sr_in);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p0_in = (LW+GW+1)'(sm_ff) * (LW+GW+1)'(fre_pkg::GAIN_ONE - g);
            p1_in = (LW+GW+1)'(rms_ff) * (LW+GW+1)'(g);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff) begin
               sm_in = LW'(acc >> 16);
               out_in.level = LW'(acc >> 16);
               out_in.final_frame = last_ff;
               out_valid_in = 1'b1;
               if (last_ff) sm_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sm_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sm_ff <= sm_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      it_ff <= it_in;
      sx_ff <= sx_in;
      sr_ff <= sr_in;
      rms_ff <= rms_in;
      last_ff <= last_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      out_ff <= out_in;
   end

   `include "frame_rms_envelope_assert.svh"
   `FRE_ASSERT(a_lvl_range, clock, reset, !out_valid_ff || out_ff.level <= fre_pkg::GAIN_ONE, "level above full scale")
   `FRE_ASSERT_NEXT(a_out_hold, clock, reset, out_valid_ff && !out_ready, out_valid_ff && $stable(out_ff), "result lost")
   `FRE_ASSERT(a_rms_range, clock, reset, state_ff != ST_MUL || rms_ff <= (RTW'(1) << LEVEL_FRAC_BITS), "rms above full scale")
endmodule
`default_nettype wire

>>> hdl/frame_rms_envelope.sv
// frame rms envelope
// req channel: push a beat of sample and last_sample while full is low.
// rsp channel: while empty is low the oldest level is on rsp_data; pop takes it.
// csr port: index 0 sample_rate, 1 frame_rate, 2 smoothing_gain, written when
// csr_write is high; write only while idle.
// each window boundary or last sample yields one level beat while neither
// rate is zero and frame_rate <= sample_rate; else a last sample only
// clears state. the front end registers a sample's magnitude, reduces
// the residual by subtracts if it is not below a lowered sample_rate,
// then squares and accumulates, taking no new sample before that. a
// closed window goes through restoring divide (one quotient bit a cycle),
// square root, multiply and output; empty or saturated windows skip the root.
// the front keeps one closed window waiting while the back end works.
// reset clears all sums, the residual, the smoothed level and the
// registers return to 48000, 60 and 18580.
// when pop stays low the result is held and both parts stall in turn,
// with full raised; no beat is dropped.
`default_nettype none
module frame_rms_envelope #(
   parameter int SAMPLE_BITS = fre_pkg::SAMPLE_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = fre_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic full,
   input  wire fre_pkg::req_type req_data,
   output logic empty,
   input  wire logic pop,
   output fre_pkg::rsp_type rsp_data,
   input  wire logic csr_write,
   input  wire logic [fre_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fre_pkg::CSR_W-1:0] csr_data
);
   logic [fre_pkg::SR_W-1:0] sr_ff;
   logic [fre_pkg::FR_W-1:0] fr_ff;
   logic [fre_pkg::GAIN_W-1:0] gain_ff;
   logic in_ready, win_valid, win_ready, clr, out_valid;
   fre_pkg::win_type win;

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff <= fre_pkg::SR_RESET;
         fr_ff <= fre_pkg::FR_RESET;
         gain_ff <= fre_pkg::GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            fre_pkg::REG_SAMPLE_RATE: sr_ff <= csr_data[fre_pkg::SR_W-1:0];
            fre_pkg::REG_FRAME_RATE: fr_ff <= csr_data[fre_pkg::FR_W-1:0];
            fre_pkg::REG_SMOOTHING_GAIN: gain_ff <= csr_data[fre_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign full = !in_ready;
   assign empty = !out_valid;

   fre_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_sample(req_data.sample[SAMPLE_BITS-1:0]),
      .in_last(req_data.last_sample), .in_ready(in_ready),
      .sample_rate(sr_ff), .frame_rate(fr_ff),
      .win_valid(win_valid), .win(win), .win_ready(win_ready),
      .clr_smooth(clr)
   );

   fre_back #(.SAMPLE_BITS(SAMPLE_BITS), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .win_valid(win_valid), .win(win), .win_ready(win_ready),
      .clr_smooth(clr), .smoothing_gain(gain_ff),
      .out_valid(out_valid), .out_data(rsp_data), .out_ready(pop)
   );
endmodule
`default_nettype wire
